// ===== src/noa_pkg.sv =====
// ----------------------------------------------------------------------------
// noa_pkg
// Shared types, constants and tables of the note oscillator.
// ----------------------------------------------------------------------------
package noa_pkg;

    localparam int OCTAVES           = 10;
    localparam int MAX_LOG_HARMONICS = 10;
    localparam int H_W               = MAX_LOG_HARMONICS + 2;

    localparam logic [1:0] CFG_METHOD   = 2'd0;
    localparam logic [1:0] CFG_LOG_HARM = 2'd1;
    localparam logic [1:0] CFG_RATE     = 2'd2;

    localparam logic [1:0] METHOD_SILENT   = 2'd0;
    localparam logic [1:0] METHOD_NAIVE    = 2'd1;
    localparam logic [1:0] METHOD_ADDITIVE = 2'd2;
    localparam logic [1:0] METHOD_UNUSED   = 2'd3;

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_TRI    = 2'd3;

    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [31:0] LN2_Q30     = 32'd620218;
    localparam logic [31:0] RECIP3_Q17  = 32'd43691;
    localparam logic [31:0] RECIP255_Q32 = 32'd16843010;
    localparam logic [31:0] SIN_C11     = 32'd3864;

    typedef enum logic [2:0] {
        K_ZERO,
        K_SILENT,
        K_SINE,
        K_NAIVE,
        K_ADD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         octave;
        logic [3:0]         semitone;
        logic signed [6:0]  cent;
        logic [7:0]         level;
        logic [1:0]         waveform;
    } t_item;

    typedef struct packed {
        logic [3:0]  log_harm;
        logic [17:0] rate;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [6:0]  count;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    function automatic logic [31:0] note_q22(input logic [3:0] semi);
        logic [31:0] v;
        case (semi)
            4'd0:    v = 32'd1097337155;
            4'd1:    v = 32'd1162588218;
            4'd2:    v = 32'd1231719311;
            4'd3:    v = 32'd1304961152;
            4'd4:    v = 32'd1382558181;
            4'd5:    v = 32'd1464769368;
            4'd6:    v = 32'd1551869087;
            4'd7:    v = 32'd1644148025;
            4'd8:    v = 32'd1741914154;
            4'd9:    v = 32'd1845493760;
            4'd10:   v = 32'd1955232530;
            default: v = 32'd2071496706;
        endcase
        return v;
    endfunction

    // horner coefficients after c11, highest order first
    function automatic logic [31:0] sin_coef(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0:    v = 32'd172272;
            3'd1:    v = 32'd5026995;
            3'd2:    v = 32'd85569306;
            3'd3:    v = 32'd693598668;
            default: v = 32'd1686629713;
        endcase
        return v;
    endfunction

endpackage

// ===== src/note_oscillator_additive_unit.sv =====
// ----------------------------------------------------------------------------
// note_oscillator_additive_unit
// Note oscillator with sine, naive and band-limited additive waveforms.
// ----------------------------------------------------------------------------
// One input word is one sample tick of a voice; one output word carries the
// saturated Q1.15 sample. The front stage clamps and classifies each word into
// a two-entry queue, so up to two words are taken while the back stage works.
// The back stage runs every step on a single 32x32 multiplier and a shared
// bit-serial divider. A disabled tick goes straight to the output; a sine,
// naive or silent tick is dominated by the wait on the 46-step phase
// increment division; an additive tick adds, per harmonic below Nyquist, a
// wait on the 25-step weight division (after squaring the harmonic number
// for triangle) and a sine evaluation, up to 1024 harmonics at the largest
// harmonic setting.
module note_oscillator_additive_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_enable,
    input  logic [3:0]         i_octave,
    input  logic [3:0]         i_semitone,
    input  logic signed [6:0]  i_cent_offset,
    input  logic [7:0]         i_level,
    input  logic [1:0]         i_waveform,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [17:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample
);
    import noa_pkg::*;

    t_item q_in;
    t_item q_out;
    t_cfg  cfg;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    noa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_enable      (i_enable),
        .i_octave      (i_octave),
        .i_semitone    (i_semitone),
        .i_cent_offset (i_cent_offset),
        .i_level       (i_level),
        .i_waveform    (i_waveform),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_full        (full),
        .o_push        (push),
        .o_item        (q_in),
        .o_cfg         (cfg)
    );

    noa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (q_in),
        .i_pop   (pop),
        .o_item  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    noa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_item      (q_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample)
    );

endmodule

// ===== src/noa_queue.sv =====
// ----------------------------------------------------------------------------
// noa_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module noa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  noa_pkg::t_item i_item,
    input  logic          i_pop,
    output noa_pkg::t_item o_item,
    output logic          o_full,
    output logic          o_empty
);
    import noa_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== src/noa_front.sv =====
// ----------------------------------------------------------------------------
// noa_front
// Configuration registers, input clamping and classification of each word.
// ----------------------------------------------------------------------------
module noa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_enable,
    input  logic [3:0]          i_octave,
    input  logic [3:0]          i_semitone,
    input  logic signed [6:0]   i_cent_offset,
    input  logic [7:0]          i_level,
    input  logic [1:0]          i_waveform,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [17:0]         i_cfg_data,
    input  logic                i_full,
    output logic                o_push,
    output noa_pkg::t_item      o_item,
    output noa_pkg::t_cfg       o_cfg
);
    import noa_pkg::*;

    logic [1:0]  r_method;
    logic [3:0]  r_log_harm;
    logic [17:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method   <= METHOD_NAIVE;
            r_log_harm <= 4'd4;
            r_rate     <= 18'd48000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_METHOD:   r_method   <= i_cfg_data[1:0];
                CFG_LOG_HARM: r_log_harm <= i_cfg_data[3:0];
                CFG_RATE:     r_rate     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        o_cfg.log_harm = (r_log_harm > 4'(MAX_LOG_HARMONICS)) ?
                         4'(MAX_LOG_HARMONICS) : r_log_harm;
        o_cfg.rate     = (r_rate == 18'd0) ? 18'd1 : r_rate;
    end

    always_comb begin
        o_item.octave   = (i_octave > 4'(OCTAVES - 1)) ? 4'(OCTAVES - 1) : i_octave;
        o_item.semitone = (i_semitone > 4'd11) ? 4'd11 : i_semitone;
        if (i_cent_offset < -7'sd50) begin
            o_item.cent = -7'sd50;
        end else if (i_cent_offset > 7'sd49) begin
            o_item.cent = 7'sd49;
        end else begin
            o_item.cent = i_cent_offset;
        end
        o_item.level    = i_level;
        o_item.waveform = i_waveform;
        if (!i_enable) begin
            o_item.kind = K_ZERO;
        end else if (i_waveform == WAVE_SINE) begin
            o_item.kind = K_SINE;
        end else if (r_method == METHOD_NAIVE) begin
            o_item.kind = K_NAIVE;
        end else if (r_method == METHOD_ADDITIVE) begin
            o_item.kind = K_ADD;
        end else begin
            o_item.kind = K_SILENT;
        end
    end

    assign o_push     = i_in_valid && !i_full;
    assign o_in_stall = i_full;

endmodule

// ===== src/noa_div.sv =====
// ----------------------------------------------------------------------------
// noa_div
// Shared bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module noa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  noa_pkg::t_div_req i_req,
    output noa_pkg::t_div_rsp o_rsp
);
    import noa_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [32:0] rem_sh;
    logic [32:0] rem_nx;
    logic        fits;

    always_comb begin
        rem_sh = {r_r, r_q[63]};
        fits   = (rem_sh >= {1'b0, r_d});
        rem_nx = fits ? (rem_sh - {1'b0, r_d}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
                r_q    <= i_req.dividend;
                r_r    <= 32'd0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                r_r   <= rem_nx[31:0];
                r_q   <= {r_q[62:0], fits};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== src/noa_back.sv =====
// ----------------------------------------------------------------------------
// noa_back
// Sequencer over one multiplier and the shared divider: pitch, increment,
// waveform, harmonic sum, scaling and phase update.
// ----------------------------------------------------------------------------
module noa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  noa_pkg::t_cfg       i_cfg,
    input  logic                i_empty,
    input  noa_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_sample
);
    import noa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_INC, ST_INC_W,
        ST_SN0, ST_SN1, ST_SN2, ST_SN3,
        ST_A_INIT, ST_A_CHK, ST_A_SQ, ST_A_DW, ST_A_TERM, ST_A_ACC,
        ST_A_FIN, ST_A_QW, ST_SC0, ST_SC1, ST_SC2, ST_OUT
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    t_item  r_item, n_item;
    logic [31:0]          r_phase, n_phase;
    logic [31:0]          r_freq, n_freq;
    logic [45:0]          r_inc, n_inc;
    logic [31:0]          r_ma, n_ma, r_mb, n_mb;
    logic [24:0]          r_a, n_a;
    logic [2:0]           r_k, n_k;
    logic [30:0]          r_x, n_x, r_x2, n_x2;
    logic [31:0]          r_sp, n_sp;
    logic [30:0]          r_smag, n_smag;
    logic                 r_sneg, n_sneg;
    logic [H_W-1:0]       r_h, n_h, r_last, n_last;
    logic [H_W+31:0]      r_hf, n_hf;
    logic [31:0]          r_ph, n_ph;
    logic [31:0]          r_sumw, n_sumw;
    logic [63:0]          r_acc, n_acc;
    logic                 r_alt, n_alt;
    logic [24:0]          r_w, n_w;
    logic [30:0]          r_wmag, n_wmag;
    logic                 r_wneg, n_wneg;
    logic [15:0]          r_res, n_res;
    logic                 r_ovalid, n_ovalid;
    logic [15:0]          r_osample, n_osample;
    t_div_req             r_dreq, n_dreq;
    t_div_rsp             drsp;

    logic [63:0] mul_p;
    logic [5:0]  cabs;
    logic [31:0] ratio;
    logic [5:0]  sh;
    logic [63:0] rsum;
    logic [63:0] fval;
    logic [30:0] xq;
    logic [32:0] sdiff;
    logic [32:0] sres;
    logic [33:0] nv;
    logic [33:0] nmag;
    logic [32:0] tri_t;
    logic        dbl;
    logic [55:0] term;
    logic [15:0] qv;
    logic [46:0] pnext;

    assign mul_p = r_ma * r_mb;
    assign dbl   = (r_item.waveform != WAVE_SAW);

    noa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (drsp)
    );

    // naive waveforms
    always_comb begin
        tri_t = (r_phase <= 32'h8000_0000) ? {1'b0, r_phase} :
                (33'h1_0000_0000 - {1'b0, r_phase});
        case (r_item.waveform)
            WAVE_SAW:    nv = {3'b0, r_phase[31:1]} - {2'b0, ONE_Q30};
            WAVE_SQUARE: nv = (r_phase > 32'h8000_0000) ? {2'b0, ONE_Q30} :
                              (34'd0 - {2'b0, ONE_Q30});
            default:     nv = {1'b0, tri_t} - {2'b0, ONE_Q30};
        endcase
        nmag = nv[33] ? (34'd0 - nv) : nv;
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_item = r_item;
        n_phase = r_phase;   n_freq = r_freq;   n_inc = r_inc;
        n_ma = r_ma;         n_mb = r_mb;       n_a = r_a;
        n_k = r_k;           n_x = r_x;         n_x2 = r_x2;
        n_sp = r_sp;         n_smag = r_smag;   n_sneg = r_sneg;
        n_h = r_h;           n_last = r_last;   n_hf = r_hf;
        n_ph = r_ph;         n_sumw = r_sumw;   n_acc = r_acc;
        n_alt = r_alt;       n_w = r_w;         n_wmag = r_wmag;
        n_wneg = r_wneg;     n_res = r_res;     n_osample = r_osample;
        n_ovalid = r_ovalid && i_out_stall;
        n_dreq = r_dreq;
        n_dreq.start = 1'b0;
        o_pop = 1'b0;

        cabs  = r_item.cent[6] ? 6'(7'd0 - r_item.cent) : r_item.cent[5:0];
        ratio = 32'd0;
        sh    = 6'd38 - {2'b0, r_item.octave};
        rsum  = mul_p + (64'd1 << (sh - 6'd1));
        fval  = rsum >> sh;
        xq    = r_sp[30] ? (31'(ONE_Q30) - {1'b0, r_sp[29:0]}) : {1'b0, r_sp[29:0]};
        sdiff = {1'b0, sin_coef(r_k)} - mul_p[62:30];
        sres  = (mul_p[62:30] > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : mul_p[62:30];
        term  = mul_p[55:0];
        qv    = mul_p[47:32];
        pnext = {15'd0, r_phase} + {1'b0, r_inc};

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    if (i_item.kind == K_ZERO) begin
                        n_res   = 16'd0;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_C0;
                    end
                end
            end
            ST_C0: begin
                n_ma = {26'd0, cabs};
                n_mb = LN2_Q30;
                n_state = ST_C1;
            end
            ST_C1: begin
                n_a  = mul_p[24:0];
                n_ma = {7'd0, mul_p[24:0]};
                n_mb = {7'd0, mul_p[24:0]};
                n_state = ST_C2;
            end
            ST_C2: begin
                n_ma = {13'd0, mul_p[49:31]};
                n_mb = {7'd0, r_a};
                n_x2 = {12'd0, mul_p[49:31]};
                n_state = ST_C3;
            end
            ST_C3: begin
                n_ma = {18'd0, mul_p[43:30]};
                n_mb = RECIP3_Q17;
                n_state = ST_C4;
            end
            ST_C4: begin
                if (!r_item.cent[6]) begin
                    ratio = ONE_Q30 + {7'd0, r_a} + {1'b0, r_x2} + {19'd0, mul_p[29:17]};
                end else begin
                    ratio = ONE_Q30 - {7'd0, r_a} + {1'b0, r_x2} - {19'd0, mul_p[29:17]};
                end
                n_ma = note_q22(r_item.semitone);
                n_mb = ratio;
                n_state = ST_C5;
            end
            ST_C5: begin
                n_freq  = (fval[63:32] != 32'd0) ? 32'hFFFF_FFFF : fval[31:0];
                n_state = ST_INC;
            end
            ST_INC: begin
                n_dreq.start    = 1'b1;
                n_dreq.dividend = {r_freq, 32'd0};
                n_dreq.count    = 7'd46;
                n_dreq.divisor  = {14'd0, i_cfg.rate};
                n_state = ST_INC_W;
            end
            ST_INC_W: begin
                if (drsp.done) begin
                    n_inc = drsp.quot[45:0];
                    case (r_item.kind)
                        K_SINE: begin
                            n_sp    = r_phase;
                            n_ret   = ST_SC0;
                            n_state = ST_SN0;
                        end
                        K_NAIVE: begin
                            n_wmag  = nmag[30:0];
                            n_wneg  = nv[33];
                            n_state = ST_SC0;
                        end
                        K_ADD: n_state = ST_A_INIT;
                        default: begin
                            n_wmag  = 31'd0;
                            n_wneg  = 1'b0;
                            n_state = ST_SC0;
                        end
                    endcase
                end
            end
            ST_SN0: begin
                n_x  = xq;
                n_ma = {1'b0, xq};
                n_mb = {1'b0, xq};
                n_state = ST_SN1;
            end
            ST_SN1: begin
                n_x2 = mul_p[60:30];
                n_ma = {1'b0, mul_p[60:30]};
                n_mb = SIN_C11;
                n_k  = 3'd0;
                n_state = ST_SN2;
            end
            ST_SN2: begin
                n_mb = sdiff[31:0];
                if (r_k == 3'd4) begin
                    n_ma = {1'b0, r_x};
                    n_state = ST_SN3;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_SN3: begin
                n_smag  = sres[30:0];
                n_sneg  = r_sp[31];
                n_wmag  = sres[30:0];
                n_wneg  = r_sp[31];
                n_state = r_ret;
            end
            ST_A_INIT: begin
                n_last = (H_W'(1) << i_cfg.log_harm) << dbl;
                n_h    = H_W'(1);
                n_hf   = {{H_W{1'b0}}, r_freq};
                n_ph   = r_phase;
                n_sumw = 32'd0;
                n_acc  = 64'd0;
                n_alt  = 1'b0;
                n_state = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (r_h > r_last ||
                    ((64'(r_hf) << 1) >= 64'({i_cfg.rate, 18'd0}))) begin
                    n_state = ST_A_FIN;
                end else if (r_item.waveform == WAVE_TRI) begin
                    n_ma = 32'(r_h);
                    n_mb = 32'(r_h);
                    n_state = ST_A_SQ;
                end else begin
                    n_dreq.start    = 1'b1;
                    n_dreq.dividend = 64'h8000_0000_0000_0000;
                    n_dreq.count    = 7'd25;
                    n_dreq.divisor  = 32'(r_h);
                    n_state = ST_A_DW;
                end
            end
            ST_A_SQ: begin
                n_dreq.start    = 1'b1;
                n_dreq.dividend = 64'h8000_0000_0000_0000;
                n_dreq.count    = 7'd25;
                n_dreq.divisor  = mul_p[31:0];
                n_state = ST_A_DW;
            end
            ST_A_DW: begin
                if (drsp.done) begin
                    n_w     = drsp.quot[24:0];
                    n_sumw  = r_sumw + {7'd0, drsp.quot[24:0]};
                    n_sp    = r_ph;
                    n_ret   = ST_A_TERM;
                    n_state = ST_SN0;
                end
            end
            ST_A_TERM: begin
                n_ma = {1'b0, r_smag};
                n_mb = {7'd0, r_w};
                n_state = ST_A_ACC;
            end
            ST_A_ACC: begin
                if (r_sneg ^ r_alt) begin
                    n_acc = r_acc - {8'd0, term};
                end else begin
                    n_acc = r_acc + {8'd0, term};
                end
                if (r_item.waveform == WAVE_TRI) begin
                    n_alt = !r_alt;
                end
                n_h  = r_h + (dbl ? H_W'(2) : H_W'(1));
                n_hf = r_hf + ({{H_W{1'b0}}, r_freq} << dbl);
                n_ph = r_ph + (r_phase << dbl);
                n_state = ST_A_CHK;
            end
            ST_A_FIN: begin
                if (r_sumw == 32'd0) begin
                    n_wmag  = 31'd0;
                    n_wneg  = 1'b0;
                    n_state = ST_SC0;
                end else begin
                    n_dreq.start    = 1'b1;
                    n_dreq.dividend = r_acc[63] ? (64'd0 - r_acc) : r_acc;
                    n_dreq.count    = 7'd64;
                    n_dreq.divisor  = r_sumw;
                    n_state = ST_A_QW;
                end
            end
            ST_A_QW: begin
                if (drsp.done) begin
                    n_wmag  = drsp.quot[30:0];
                    n_wneg  = r_acc[63];
                    n_state = ST_SC0;
                end
            end
            ST_SC0: begin
                n_ma = {1'b0, r_wmag};
                n_mb = {24'd0, r_item.level};
                n_state = ST_SC1;
            end
            ST_SC1: begin
                n_ma = {8'd0, mul_p[38:15]};
                n_mb = RECIP255_Q32;
                n_state = ST_SC2;
            end
            ST_SC2: begin
                if (!r_wneg) begin
                    n_res = (qv > 16'd32767) ? 16'h7FFF : qv;
                end else begin
                    n_res = (qv > 16'd32768) ? 16'h8000 : (16'd0 - qv);
                end
                n_phase = (pnext[46:32] != 15'd0) ? 32'd0 : pnext[31:0];
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid  = 1'b1;
                    n_osample = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_SC0;
            r_phase  <= 32'd0;
            r_ovalid <= 1'b0;
            r_dreq   <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
            r_dreq   <= n_dreq;
        end
        r_item <= n_item;   r_freq <= n_freq;   r_inc <= n_inc;
        r_ma <= n_ma;       r_mb <= n_mb;       r_a <= n_a;
        r_k <= n_k;         r_x <= n_x;         r_x2 <= n_x2;
        r_sp <= n_sp;       r_smag <= n_smag;   r_sneg <= n_sneg;
        r_h <= n_h;         r_last <= n_last;   r_hf <= n_hf;
        r_ph <= n_ph;       r_sumw <= n_sumw;   r_acc <= n_acc;
        r_alt <= n_alt;     r_w <= n_w;         r_wmag <= n_wmag;
        r_wneg <= n_wneg;   r_res <= n_res;     r_osample <= n_osample;
    end

    assign o_out_valid = r_ovalid;
    assign o_sample    = r_osample;

endmodule

// ===== src/noa_checker.sv =====
// ----------------------------------------------------------------------------
// noa_checker
// Port-level checks of the note oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module noa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_sample
);

    // reset leaves no word pending at the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the queue
    a_rst_queue: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample))
        else $error("stalled output word changed");

endmodule

bind note_oscillator_additive_unit noa_checker u_noa_checker (.*);

// ===== tb/note_oscillator_additive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_oscillator_additive_checker
// Watches the input, configuration and output ports of the note oscillator.
// Every accepted input word is run through a bit-exact model of the pitch
// table, the phase accumulator and the sine, naive and additive waveforms.
// The predicted sample is queued and compared with the next output word.
// ----------------------------------------------------------------------------
module note_oscillator_additive_checker
    import noa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_enable,
    input  logic [3:0]         i_octave,
    input  logic [3:0]         i_semitone,
    input  logic signed [6:0]  i_cent_offset,
    input  logic [7:0]         i_level,
    input  logic [1:0]         i_waveform,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [17:0]        i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_sample,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint unsigned UNIT_Q30 = 64'd1073741824;

    logic [31:0] pitch_rom [12] = '{
        32'd1097337155, 32'd1162588218, 32'd1231719311, 32'd1304961152,
        32'd1382558181, 32'd1464769368, 32'd1551869087, 32'd1644148025,
        32'd1741914154, 32'd1845493760, 32'd1955232530, 32'd2071496706
    };

    logic [1:0]  method_q;
    logic [3:0]  harm_log_q;
    logic [17:0] rate_q;
    logic [31:0] phase_q;
    logic signed [15:0] expected_samples [$];

    function automatic longint unsigned detune_ratio(input int cents);
        longint unsigned a, t2, t3;
        a  = longint'(cents < 0 ? -cents : cents) * 64'd620218;
        t2 = (a * a) >> 31;
        t3 = ((t2 * a) >> 30) / 64'd3;
        if (cents >= 0) begin
            return UNIT_Q30 + a + t2 + t3;
        end
        return UNIT_Q30 - a + t2 - t3;
    endfunction

    function automatic logic [31:0] pitch_q18(input logic [3:0] oct, input logic [3:0] semi,
                                              input logic signed [6:0] cent);
        int o, n, c, sh;
        longint unsigned prod, val;
        o = oct > OCTAVES - 1 ? OCTAVES - 1 : oct;
        n = semi > 11 ? 11 : semi;
        c = cent;
        if (c < -50) c = -50;
        if (c > 49) c = 49;
        prod = longint'(pitch_rom[n]) * detune_ratio(c);
        sh   = 38 - o;
        val  = (prod + (64'd1 << (sh - 1))) >> sh;
        if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
        return val[31:0];
    endfunction

    function automatic longint sine_wave(input logic [31:0] p);
        longint unsigned x, x2, s;
        x = {34'd0, p[29:0]};
        if (p[30]) x = UNIT_Q30 - x;
        x2 = (x * x) >> 30;
        s = 64'd3864;
        s = 64'd172272 - ((x2 * s) >> 30);
        s = 64'd5026995 - ((x2 * s) >> 30);
        s = 64'd85569306 - ((x2 * s) >> 30);
        s = 64'd693598668 - ((x2 * s) >> 30);
        s = 64'd1686629713 - ((x2 * s) >> 30);
        s = (x * s) >> 30;
        if (s > UNIT_Q30) s = UNIT_Q30;
        return p[31] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint naive_wave(input logic [1:0] wave, input logic [31:0] p);
        longint unsigned t;
        if (wave == WAVE_SAW) begin
            return longint'({33'd0, p[31:1]}) - longint'(UNIT_Q30);
        end
        if (wave == WAVE_SQUARE) begin
            return p > 32'h8000_0000 ? longint'(UNIT_Q30) : -longint'(UNIT_Q30);
        end
        t = p <= 32'h8000_0000 ? {32'd0, p} : 64'h1_0000_0000 - {32'd0, p};
        return longint'(t) - longint'(UNIT_Q30);
    endfunction

    function automatic longint additive_wave(input logic [1:0] wave, input logic [31:0] p,
                                             input logic [31:0] freq, input longint unsigned rate,
                                             input logic [3:0] hlog);
        longint unsigned lh, step, last, nyq, h, hr, w, sum_w;
        longint acc, term;
        logic [31:0] hp;
        bit neg;
        lh    = hlog > MAX_LOG_HARMONICS ? MAX_LOG_HARMONICS : hlog;
        step  = wave == WAVE_SAW ? 1 : 2;
        last  = (64'd1 << lh) * step;
        nyq   = rate << 18;
        sum_w = 0;
        acc   = 0;
        neg   = 0;
        for (h = 1; h <= last; h += step) begin
            if (h * freq * 2 >= nyq) break;
            hr    = wave == WAVE_TRI ? h * h : h;
            w     = (64'd1 << 24) / hr;
            sum_w += w;
            hp    = p * h[31:0];
            term  = sine_wave(hp) * longint'(w);
            acc   += neg ? -term : term;
            if (wave == WAVE_TRI) neg = !neg;
        end
        if (sum_w == 0) return 0;
        return acc / longint'(sum_w);
    endfunction

    // advances the voice phase as a side effect
    function automatic logic signed [15:0] next_sample(input logic en, input logic [3:0] oct,
                                                       input logic [3:0] semi,
                                                       input logic signed [6:0] cent,
                                                       input logic [7:0] lvl,
                                                       input logic [1:0] wave);
        longint unsigned rate, nxt;
        logic [31:0] freq;
        longint w, s;
        if (!en) return 16'sd0;
        rate = rate_q == 0 ? 1 : rate_q;
        freq = pitch_q18(oct, semi, cent);
        if (wave == WAVE_SINE) w = sine_wave(phase_q);
        else if (method_q == METHOD_NAIVE) w = naive_wave(wave, phase_q);
        else if (method_q == METHOD_ADDITIVE) w = additive_wave(wave, phase_q, freq, rate,
                                                                harm_log_q);
        else w = 0;
        s = (w * longint'(lvl)) / longint'(255 * 32768);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        nxt = {32'd0, phase_q} + (({32'd0, freq} << 14) / rate);
        phase_q = nxt >= 64'h1_0000_0000 ? 32'd0 : nxt[31:0];
        return s[15:0];
    endfunction

    assign o_pending = expected_samples.size();

    initial begin
        o_errors = 0;
    end

    always @(posedge i_clk) begin
        logic signed [15:0] exp_s;
        if (!i_rst_n) begin
            method_q   <= METHOD_NAIVE;
            harm_log_q <= 4'd4;
            rate_q     <= 18'd48000;
            phase_q    <= '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_METHOD:   method_q <= i_cfg_data[1:0];
                    CFG_LOG_HARM: harm_log_q <= i_cfg_data[3:0];
                    CFG_RATE:     rate_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_samples.push_back(next_sample(i_enable, i_octave, i_semitone,
                                                       i_cent_offset, i_level, i_waveform));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected output word, sample %0d", i_sample);
                    o_errors++;
                end else begin
                    exp_s = expected_samples.pop_front();
                    if (exp_s !== i_sample) begin
                        $error("sample mismatch: expected %0d, actual %0d", exp_s, i_sample);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_note_oscillator_additive_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_note_oscillator_additive_unit
// Drives the note oscillator through several method, harmonic and rate
// settings: a directed sweep of field extremes, then random ticks with random
// gaps and output stalls, including a long output hold-off that backs the
// block up. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_note_oscillator_additive_unit;
    import noa_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_enable;
    logic [3:0]         i_octave;
    logic [3:0]         i_semitone;
    logic signed [6:0]  i_cent_offset;
    logic [7:0]         i_level;
    logic [1:0]         i_waveform;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [17:0]        i_cfg_data;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_sample;
    int                 errors;
    int                 pending;
    bit                 hold_off;
    bit                 burst;

    note_oscillator_additive_unit dut (.*);

    note_oscillator_additive_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_enable      (i_enable),
        .i_octave      (i_octave),
        .i_semitone    (i_semitone),
        .i_cent_offset (i_cent_offset),
        .i_level       (i_level),
        .i_waveform    (i_waveform),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_sample      (o_sample),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("note_oscillator_additive_unit test failed");
        $finish;
    end

    // output side
    initial begin
        int n;
        i_out_stall = 1'b1;
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_word(input logic en, input logic [3:0] oct, input logic [3:0] semi,
                             input logic signed [6:0] cent, input logic [7:0] lvl,
                             input logic [1:0] wave);
        int n;
        if ($urandom_range(0, 7) == 0) burst = !burst;
        n = burst ? 0 : $urandom_range(0, 18);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_enable      <= en;
        i_octave      <= oct;
        i_semitone    <= semi;
        i_cent_offset <= cent;
        i_level       <= lvl;
        i_waveform    <= wave;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random(input int count, input int oct_lo, input int oct_hi);
        logic signed [6:0] cent;
        logic [3:0] semi;
        repeat (count) begin
            semi = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 11));
            cent = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($signed($urandom_range(0, 99)) - 50);
            send_word($urandom_range(0, 9) != 0, 4'($urandom_range(oct_lo, oct_hi)), semi,
                      cent, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic configure(input logic [1:0] method, input logic [3:0] hlog,
                             input logic [17:0] rate);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_METHOD;
        i_cfg_data <= {16'd0, method};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LOG_HARM;
        i_cfg_data <= {14'd0, hlog};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RATE;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_enable      = 1'b0;
        i_octave      = '0;
        i_semitone    = '0;
        i_cent_offset = '0;
        i_level       = '0;
        i_waveform    = WAVE_SINE;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_METHOD;
        i_cfg_data    = '0;
        hold_off      = 0;
        burst         = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sweep at reset settings
        send_word(1'b0, 4'd4, 4'd9, 7'sd0, 8'd255, WAVE_SINE);
        for (int wv = 0; wv < 4; wv++) begin
            send_word(1'b1, 4'd0, 4'd0, -7'sd50, 8'd255, wv[1:0]);
            send_word(1'b1, 4'd9, 4'd11, 7'sd49, 8'd255, wv[1:0]);
            send_word(1'b1, 4'd15, 4'd15, 7'sd63, 8'd128, wv[1:0]);
            send_word(1'b1, 4'd4, 4'd9, -7'sd64, 8'd0, wv[1:0]);
        end
        send_word(1'b0, 4'd15, 4'd15, -7'sd1, 8'd255, WAVE_TRI);

        configure(METHOD_ADDITIVE, 4'd4, 18'd48000);
        send_random(60, 0, 15);
        configure(METHOD_ADDITIVE, 4'd0, 18'd8000);
        send_random(30, 0, 15);
        // harmonic count beyond its ceiling, highest rate field value
        configure(METHOD_ADDITIVE, 4'd15, 18'h3FFFF);
        send_random(10, 6, 15);
        configure(METHOD_SILENT, 4'd10, 18'd192000);
        send_random(40, 0, 15);
        // unused method, zero sample rate
        configure(METHOD_UNUSED, 4'd1, 18'd0);
        send_random(15, 0, 15);
        configure(METHOD_ADDITIVE, 4'd2, 18'd0);
        send_random(10, 0, 15);
        configure(METHOD_NAIVE, 4'd2, 18'd44100);
        send_random(60, 0, 15);
        configure(METHOD_ADDITIVE, 4'd6, 18'd96000);
        hold_off = 1;
        send_random(50, 0, 15);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("note_oscillator_additive_unit test passed");
        end else begin
            $display("note_oscillator_additive_unit test failed");
        end
        $finish;
    end

endmodule

// ===== note_oscillator_additive_unit.f =====
src/noa_pkg.sv
src/noa_queue.sv
src/noa_front.sv
src/noa_div.sv
src/noa_back.sv
src/note_oscillator_additive_unit.sv
src/noa_checker.sv
tb/note_oscillator_additive_checker.sv
tb/tb_note_oscillator_additive_unit.sv
